[design/irpd_pkg.sv]
// Package for the IR pulse decoder with threshold alarm.
// Holds the register indexes, reset values, key codes and the key-entry status type.
// No dependencies.
`timescale 1ns / 1ps

package irpd_pkg;

  localparam int unsigned CodeWidth   = 32;
  localparam int unsigned IntvlWidth  = 16;
  localparam int unsigned TempWidth   = 8;
  localparam int unsigned BitCntWidth = 6;
  localparam int unsigned NumDigits   = 10;
  localparam int unsigned NumSlots    = 3;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_GAP = 2'd0;
  localparam logic [1:0] CFG_ONE_MIN   = 2'd1;
  localparam logic [1:0] CFG_ZERO_MIN  = 2'd2;

  localparam logic [IntvlWidth-1:0] FRAME_GAP_RST = 16'd8000;
  localparam logic [IntvlWidth-1:0] ONE_MIN_RST   = 16'd1700;
  localparam logic [IntvlWidth-1:0] ZERO_MIN_RST  = 16'd1000;

  localparam logic [TempWidth-1:0] THRESHOLD_RST = 8'd100;

  localparam logic [CodeWidth-1:0] KEY_ARM    = 32'd16736925;
  localparam logic [CodeWidth-1:0] KEY_COMMIT = 32'd16748655;

  localparam logic [CodeWidth-1:0] DIGIT_KEYS [NumDigits] = '{
    32'd16738455, 32'd16724175, 32'd16718055, 32'd16743045, 32'd16716015,
    32'd16726215, 32'd16734885, 32'd16728765, 32'd16730805, 32'd16732845
  };

  typedef struct packed {
    logic                 armed;
    logic [1:0]           digit_count;
    logic [TempWidth-1:0] threshold;
  } irpd_key_status_t;

endpackage

[design/irpd_key_entry.sv]
// Key-entry machine: arm key, up to three digits, commit into the alarm threshold.
// Depends on irpd_pkg for key codes and the status struct.
`timescale 1ns / 1ps

module irpd_key_entry import irpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 code_en_i,
  input  logic [CodeWidth-1:0] code_i,
  output irpd_key_status_t     status_o,
  output logic                 updated_o
);

  logic                 armed_q, armed_d;
  logic [1:0]           digit_count_q, digit_count_d;
  logic [3:0]           slots_q [NumSlots];
  logic [3:0]           slots_d [NumSlots];
  logic [TempWidth-1:0] threshold_q, threshold_d;

  logic       digit_hit;
  logic [3:0] digit_val;
  logic [10:0] commit_sum;

  always_comb begin
    digit_hit = 1'b0;
    digit_val = 4'd0;
    for (int i = 0; i < NumDigits; i++) begin
      if (code_i == DIGIT_KEYS[i]) begin
        digit_hit = 1'b1;
        digit_val = 4'(i);
      end
    end
  end

  assign commit_sum = 11'(slots_q[0]) * 11'd100 + 11'(slots_q[1]) * 11'd10
                    + 11'(slots_q[2]);

  always_comb begin
    armed_d       = armed_q;
    digit_count_d = digit_count_q;
    slots_d       = slots_q;
    threshold_d   = threshold_q;
    updated_o     = 1'b0;
    if (code_en_i) begin
      if (code_i == KEY_ARM) begin
        armed_d = 1'b1;
      end else if (code_i == KEY_COMMIT) begin
        if (armed_q) begin
          // saturate the three-digit value to the 8-bit threshold
          threshold_d = (commit_sum > 11'd255) ? 8'd255 : commit_sum[TempWidth-1:0];
          updated_o   = 1'b1;
        end
        armed_d       = 1'b0;
        digit_count_d = 2'd0;
      end else if (digit_hit && armed_q && (digit_count_q < 2'(NumSlots))) begin
        slots_d[digit_count_q] = digit_val;
        digit_count_d          = digit_count_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q       <= 1'b0;
      digit_count_q <= 2'd0;
      slots_q[0]    <= 4'd1;
      slots_q[1]    <= 4'd0;
      slots_q[2]    <= 4'd0;
      threshold_q   <= THRESHOLD_RST;
    end else begin
      armed_q       <= armed_d;
      digit_count_q <= digit_count_d;
      slots_q       <= slots_d;
      threshold_q   <= threshold_d;
    end
  end

  assign status_o.armed       = armed_q;
  assign status_o.digit_count = digit_count_q;
  assign status_o.threshold   = threshold_q;

endmodule

[design/ir_pulse_decoder_threshold_alarm_top.sv]
// A word is held in the input register, then moves on into the result register.
// Throughput: one word per cycle unless out_stall_i holds the result register; edge decode,
// key entry and the temperature compare all finish in the single step from input register to result register.
// Reset (rst_ni low, asynchronous): empty pipeline, code and bit count cleared,
// threshold 100, digit slots 1,0,0, alarm clear, timing registers at 8000/1700/1000 us.
// Depends on irpd_pkg and irpd_key_entry.
`timescale 1ns / 1ps

module ir_pulse_decoder_threshold_alarm_top import irpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [IntvlWidth-1:0] cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [IntvlWidth-1:0] edge_interval_us_i,
  input  logic [TempWidth-1:0]  temperature_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  frame_valid_o,
  output logic [CodeWidth-1:0]  key_code_o,
  output logic                  entry_armed_o,
  output logic [1:0]            digits_entered_o,
  output logic [TempWidth-1:0]  alarm_threshold_o,
  output logic                  threshold_updated_o,
  output logic                  alarm_o
);

  logic [IntvlWidth-1:0] frame_gap_q, one_min_q, zero_min_q;

  logic                  in_vld_q;
  logic                  in_cmd_q;
  logic [IntvlWidth-1:0] in_intvl_q;
  logic [TempWidth-1:0]  in_temp_q;

  logic [CodeWidth-1:0]   code_shift_q, code_shift_d;
  logic [BitCntWidth-1:0] bit_count_q, bit_count_d;
  logic [CodeWidth-1:0]   last_code_q, last_code_d;
  logic                   alarm_q, alarm_d;

  logic out_vld_q;
  logic frame_valid_q, frame_valid_d;
  logic updated_q;

  logic             advance;
  logic             load_in;
  logic             code_en;
  logic             key_updated;
  irpd_key_status_t key_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_gap_q <= FRAME_GAP_RST;
      one_min_q   <= ONE_MIN_RST;
      zero_min_q  <= ZERO_MIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FRAME_GAP: frame_gap_q <= cfg_data_i;
        CFG_ONE_MIN:   one_min_q   <= cfg_data_i;
        CFG_ZERO_MIN:  zero_min_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // move a word to the result register whenever that register is free or drains
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign load_in    = !in_vld_q || advance;
  assign in_stall_o = !load_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (load_in) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in && in_valid_i) begin
      in_cmd_q   <= cmd_i;
      in_intvl_q <= edge_interval_us_i;
      in_temp_q  <= temperature_i;
    end
  end

  always_comb begin
    code_shift_d  = code_shift_q;
    bit_count_d   = bit_count_q;
    last_code_d   = last_code_q;
    alarm_d       = alarm_q;
    frame_valid_d = 1'b0;
    code_en       = 1'b0;
    if (advance) begin
      if (!in_cmd_q) begin
        if (in_intvl_q > frame_gap_q) begin
          code_shift_d = '0;
          bit_count_d  = '0;
        end else if (in_intvl_q > one_min_q) begin
          // MSB first: bit position is 31 - count
          code_shift_d[~bit_count_q[4:0]] = 1'b1;
          bit_count_d = bit_count_q + 6'd1;
        end else if (in_intvl_q > zero_min_q) begin
          code_shift_d[~bit_count_q[4:0]] = 1'b0;
          bit_count_d = bit_count_q + 6'd1;
        end
        if (bit_count_d[5]) begin
          bit_count_d = '0;
          if ((~code_shift_d[7:0]) == code_shift_d[15:8]) begin
            last_code_d   = code_shift_d;
            frame_valid_d = 1'b1;
            code_en       = 1'b1;
          end
        end
      end else begin
        alarm_d = in_temp_q > key_status.threshold;
      end
    end
  end

  irpd_key_entry u_key_entry (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .code_en_i (code_en),
    .code_i    (code_shift_d),
    .status_o  (key_status),
    .updated_o (key_updated)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_shift_q  <= '0;
      bit_count_q   <= '0;
      last_code_q   <= '0;
      alarm_q       <= 1'b0;
      out_vld_q     <= 1'b0;
      frame_valid_q <= 1'b0;
      updated_q     <= 1'b0;
    end else begin
      code_shift_q <= code_shift_d;
      bit_count_q  <= bit_count_d;
      last_code_q  <= last_code_d;
      alarm_q      <= alarm_d;
      if (advance) begin
        out_vld_q     <= 1'b1;
        frame_valid_q <= frame_valid_d;
        updated_q     <= key_updated;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // state changes only when a result is loaded, so it doubles as the held payload
  assign out_valid_o         = out_vld_q;
  assign frame_valid_o       = frame_valid_q;
  assign key_code_o          = last_code_q;
  assign entry_armed_o       = key_status.armed;
  assign digits_entered_o    = key_status.digit_count;
  assign alarm_threshold_o   = key_status.threshold;
  assign threshold_updated_o = updated_q;
  assign alarm_o             = alarm_q;

`ifndef SYNTHESIS
  a_frame_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && frame_valid_q |-> (~last_code_q[7:0]) == last_code_q[15:8])
    else $error("accepted code fails the inverse byte check");

  a_commit_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && updated_q |-> !key_status.armed && key_status.digit_count == 2'd0)
    else $error("commit left entry armed or digits pending");

  a_update_needs_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && updated_q |-> frame_valid_q)
    else $error("threshold update without an accepted code");

  a_temp_keeps_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_cmd_q |=> $stable(last_code_q) && $stable(bit_count_q))
    else $error("temperature word disturbed the IR decoder state");

  a_bit_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> !bit_count_q[5])
    else $error("bit count passed 31 after a word");
`endif

endmodule
